// ===== hdl/toic_pkg.sv =====
// shared types, constants and register codes for the third-order iir compensator
package toic_pkg;

  localparam int SAMPLE_W = 16;
  localparam int ERR_W    = SAMPLE_W + 1;
  localparam int COEF_W   = 32;
  localparam int DRIVE_W  = 32;
  localparam int CFG_IDX_W = 3;

  // feed-forward product and shifted feedback product widths
  localparam int FF_PROD_W = COEF_W + ERR_W;
  localparam int FB_PROD_W = COEF_W + DRIVE_W;
  localparam int FB_SHIFT  = 16;
  localparam int FB_TERM_W = FB_PROD_W - FB_SHIFT;
  // seven terms, each below 2^47 in magnitude, sum below 2^50
  localparam int ACC_W     = 52;
  localparam int RND_SHIFT = 8;
  localparam int RND_W     = ACC_W - RND_SHIFT;

  localparam int UPPER_LIMIT = 32767;
  localparam int LOWER_LIMIT = -32768;

  typedef logic signed [SAMPLE_W-1:0]  sample_t;
  typedef logic signed [ERR_W-1:0]     err_t;
  typedef logic signed [COEF_W-1:0]    coef_t;
  typedef logic signed [DRIVE_W-1:0]   drive_t;
  typedef logic signed [ACC_W-1:0]     acc_t;
  typedef logic signed [RND_W-1:0]     rnd_t;
  typedef logic        [CFG_IDX_W-1:0] cfg_idx_t;

  localparam drive_t DRIVE_HI = drive_t'(UPPER_LIMIT * 65536);
  localparam drive_t DRIVE_LO = drive_t'(LOWER_LIMIT * 65536);
  localparam acc_t   RND_HALF = acc_t'(128);

  // register indexes
  localparam cfg_idx_t CFG_FF_GAIN_0 = 3'd0;
  localparam cfg_idx_t CFG_FF_GAIN_1 = 3'd1;
  localparam cfg_idx_t CFG_FF_GAIN_2 = 3'd2;
  localparam cfg_idx_t CFG_FF_GAIN_3 = 3'd3;
  localparam cfg_idx_t CFG_FB_GAIN_1 = 3'd4;
  localparam cfg_idx_t CFG_FB_GAIN_2 = 3'd5;
  localparam cfg_idx_t CFG_FB_GAIN_3 = 3'd6;

  typedef struct packed {
    coef_t ff0;
    coef_t ff1;
    coef_t ff2;
    coef_t ff3;
    coef_t fb1;
    coef_t fb2;
    coef_t fb3;
  } gains_t;

  // past errors and outputs, one to three samples back
  typedef struct packed {
    err_t   e1;
    err_t   e2;
    err_t   e3;
    drive_t y1;
    drive_t y2;
    drive_t y3;
  } hist_t;

endpackage

// ===== hdl/toic_ifs.sv =====
// valid/ready channel interfaces for samples, results and register writes
interface toic_in_if;
  logic              valid;
  logic              ready;
  toic_pkg::sample_t reference;
  toic_pkg::sample_t measured;
  modport source (output valid, output reference, output measured, input ready);
  modport sink (input valid, input reference, input measured, output ready);
endinterface

interface toic_out_if;
  logic             valid;
  logic             ready;
  toic_pkg::drive_t drive;
  logic             clamped;
  modport source (output valid, output drive, output clamped, input ready);
  modport sink (input valid, input drive, input clamped, output ready);
endinterface

interface toic_cfg_if;
  logic               valid;
  logic               ready;
  toic_pkg::cfg_idx_t index;
  toic_pkg::coef_t    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/toic_cfg_regs.sv =====
// coefficient register file written through the configuration channel
module toic_cfg_regs (
  input  logic             clk,
  input  logic             rst,
  toic_cfg_if.sink         cfg,
  output toic_pkg::gains_t gains
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      gains <= '0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        toic_pkg::CFG_FF_GAIN_0: gains.ff0 <= cfg.data;
        toic_pkg::CFG_FF_GAIN_1: gains.ff1 <= cfg.data;
        toic_pkg::CFG_FF_GAIN_2: gains.ff2 <= cfg.data;
        toic_pkg::CFG_FF_GAIN_3: gains.ff3 <= cfg.data;
        toic_pkg::CFG_FB_GAIN_1: gains.fb1 <= cfg.data;
        toic_pkg::CFG_FB_GAIN_2: gains.fb2 <= cfg.data;
        toic_pkg::CFG_FB_GAIN_3: gains.fb3 <= cfg.data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

endmodule

// ===== hdl/toic_calc.sv =====
// difference equation, rounding and output clamp for one sample
module toic_calc (
  input  toic_pkg::sample_t reference,
  input  toic_pkg::sample_t measured,
  input  toic_pkg::gains_t  gains,
  input  toic_pkg::hist_t   hist,
  output toic_pkg::err_t    e0,
  output toic_pkg::drive_t  drive,
  output logic              clamped
);

  logic signed [toic_pkg::FF_PROD_W-1:0] pff0, pff1, pff2, pff3;
  logic signed [toic_pkg::FB_PROD_W-1:0] pfb1, pfb2, pfb3;
  logic signed [toic_pkg::FB_TERM_W-1:0] tfb1, tfb2, tfb3;
  toic_pkg::acc_t acc;
  toic_pkg::acc_t acc_rnd;
  toic_pkg::rnd_t rnd;
  toic_pkg::rnd_t y_hi;
  toic_pkg::rnd_t y_clamp;
  logic           clip_hi;
  logic           clip_lo;

  assign e0 = toic_pkg::err_t'(reference) - toic_pkg::err_t'(measured);

  assign pff0 = gains.ff0 * e0;
  assign pff1 = gains.ff1 * hist.e1;
  assign pff2 = gains.ff2 * hist.e2;
  assign pff3 = gains.ff3 * hist.e3;
  assign pfb1 = gains.fb1 * hist.y1;
  assign pfb2 = gains.fb2 * hist.y2;
  assign pfb3 = gains.fb3 * hist.y3;

  // floor shift by 16 to bring feedback terms to the feed-forward scale
  assign tfb1 = pfb1[toic_pkg::FB_PROD_W-1:toic_pkg::FB_SHIFT];
  assign tfb2 = pfb2[toic_pkg::FB_PROD_W-1:toic_pkg::FB_SHIFT];
  assign tfb3 = pfb3[toic_pkg::FB_PROD_W-1:toic_pkg::FB_SHIFT];

  assign acc = toic_pkg::acc_t'(pff0) + toic_pkg::acc_t'(pff1)
             + toic_pkg::acc_t'(pff2) + toic_pkg::acc_t'(pff3)
             - toic_pkg::acc_t'(tfb1) - toic_pkg::acc_t'(tfb2)
             - toic_pkg::acc_t'(tfb3);

  // round half up to q16.16
  assign acc_rnd = acc + toic_pkg::RND_HALF;
  assign rnd     = acc_rnd[toic_pkg::ACC_W-1:toic_pkg::RND_SHIFT];

  // upper limit first, then lower limit, so lower wins when crossed
  always_comb begin
    clip_hi = rnd > toic_pkg::rnd_t'(toic_pkg::DRIVE_HI);
    y_hi    = clip_hi ? toic_pkg::rnd_t'(toic_pkg::DRIVE_HI) : rnd;
    clip_lo = y_hi < toic_pkg::rnd_t'(toic_pkg::DRIVE_LO);
    y_clamp = clip_lo ? toic_pkg::rnd_t'(toic_pkg::DRIVE_LO) : y_hi;
  end

  assign drive   = y_clamp[toic_pkg::DRIVE_W-1:0];
  assign clamped = clip_hi | clip_lo;

endmodule

// ===== hdl/third_order_iir_compensator_core.sv =====
// third-order iir compensator: input register, single-pass datapath, result register
// path: a transferred sample sits in the input register and moves through the datapath
//   into the result register, which drives result.valid, once the result stage is free
// throughput: one sample per cycle, sustained while the result side keeps taking
// the feedback path closes combinationally: input register -> datapath -> output history
// reset (rst, synchronous, active high): coefficients zero, histories zero, both stages empty
module third_order_iir_compensator_core (
  input  logic       clk,
  input  logic       rst,
  toic_in_if.sink    sample,
  toic_out_if.source result,
  toic_cfg_if.sink   cfg
);

  // input stage
  logic              in_full;
  toic_pkg::sample_t ref_q;
  toic_pkg::sample_t meas_q;

  // result stage
  logic              res_valid;
  toic_pkg::drive_t  drive_q;
  logic              clamped_q;

  // filter state
  toic_pkg::hist_t   hist;
  toic_pkg::hist_t   hist_next;
  toic_pkg::gains_t  gains;

  // datapath outputs
  toic_pkg::err_t    e0;
  toic_pkg::drive_t  y;
  logic              clip;

  // advance: the input stage moves into the result stage
  logic              adv;

  toic_cfg_regs u_cfg_regs (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .gains (gains)
  );

  toic_calc u_calc (
    .reference (ref_q),
    .measured  (meas_q),
    .gains     (gains),
    .hist      (hist),
    .e0        (e0),
    .drive     (y),
    .clamped   (clip)
  );

  // result stage is free when empty or being drained this cycle
  assign adv          = in_full && (!res_valid || result.ready);
  assign sample.ready = !in_full || adv;

  assign result.valid   = res_valid;
  assign result.drive   = drive_q;
  assign result.clamped = clamped_q;

  // input register, refilled on every sample transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (sample.valid && sample.ready) begin
      in_full <= 1'b1;
    end else if (adv) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      ref_q  <= sample.reference;
      meas_q <= sample.measured;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      drive_q   <= y;
      clamped_q <= clip;
    end
  end

  // delay lines shift once per processed sample
  always_comb begin
    hist_next    = hist;
    hist_next.e1 = e0;
    hist_next.e2 = hist.e1;
    hist_next.e3 = hist.e2;
    hist_next.y1 = y;
    hist_next.y2 = hist.y1;
    hist_next.y3 = hist.y2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist <= '0;
    end else if (adv) begin
      hist <= hist_next;
    end
  end

  // newest output history always matches the result just produced
  a_hist_tracks_result: assert property (@(posedge clk) disable iff (rst)
    adv |=> (hist.y1 == drive_q))
    else $error("output history out of step with result register");

  // newest error comes from the sample that was in the input stage
  a_err_from_input: assert property (@(posedge clk) disable iff (rst)
    adv |=> (hist.e1 == toic_pkg::err_t'($past(ref_q)) - toic_pkg::err_t'($past(meas_q))))
    else $error("error history not taken from processed sample");

  // a clamped result sits exactly on one of the limits
  a_clamp_on_limit: assert property (@(posedge clk) disable iff (rst)
    (res_valid && clamped_q) |->
      (drive_q == toic_pkg::DRIVE_HI || drive_q == toic_pkg::DRIVE_LO))
    else $error("clamped flag set off the limits");

  // a full input stage behind a stalled result holds the sample side off
  a_stall_backpressure: assert property (@(posedge clk) disable iff (rst)
    (in_full && res_valid && !result.ready) |=> (in_full && $stable(ref_q)))
    else $error("input stage lost a sample under stall");

endmodule

// ===== bench/third_order_iir_compensator_core_tb.sv =====
// self-checking bench for the third-order iir compensator core: directed table, then random phases
module third_order_iir_compensator_core_tb;
  import toic_pkg::*;

  // run shape
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 8;
  localparam int STALL_LIMIT   = 1000; // cycles without any transfer before giving up
  localparam int N_PHASES      = 10;
  localparam int PHASE_SAMPLES = 55;
  localparam int N_QUIET       = 2;    // closing phases run with no idling at all
  localparam int REPORT_CAP    = 40;   // keep the log short on a badly broken build

  // index past the last gain register, decoded by nothing
  localparam cfg_idx_t CFG_SPARE = 3'd7;
  localparam coef_t    UNITY     = 32'sh0100_0000;  // 1.0 in Q8.24
  localparam coef_t    GAIN_MIN  = 32'sh8000_0000;
  localparam coef_t    GAIN_MAX  = 32'sh7FFF_FFFF;

  localparam cfg_idx_t GAIN_REGS [7] = '{CFG_FF_GAIN_0, CFG_FF_GAIN_1, CFG_FF_GAIN_2,
                                         CFG_FF_GAIN_3, CFG_FB_GAIN_1, CFG_FB_GAIN_2,
                                         CFG_FB_GAIN_3};

  typedef enum {GAINS_ZERO, GAINS_STABLE, GAINS_FF_ONLY, GAINS_WILD, GAINS_EXTREME}
    gain_style_t;

  // coefficient mix of each random phase; the last two run without idling
  localparam gain_style_t PHASE_PLAN [N_PHASES] = '{
    GAINS_STABLE, GAINS_WILD, GAINS_FF_ONLY, GAINS_EXTREME, GAINS_STABLE,
    GAINS_ZERO, GAINS_WILD, GAINS_FF_ONLY, GAINS_STABLE, GAINS_EXTREME};

  typedef struct packed {
    drive_t drive;
    logic   clamped;
  } drive_rec_t;

  // one directed step: a register write, or a sample with an optional typed-in result
  typedef struct packed {
    logic     is_write;
    cfg_idx_t idx;
    coef_t    gain;
    sample_t  setpt;
    sample_t  fbk;
    logic     pinned;
    drive_t   drive;
    logic     clamped;
  } row_t;

  localparam int N_DIRECTED = 27;
  localparam row_t DIRECTED [N_DIRECTED] = '{
    // gains still zero after reset: output stays at zero for the widest errors
    '{1'b0, CFG_FF_GAIN_0, 32'sh0, 16'sh7FFF, 16'sh8000, 1'b1, 32'sh0, 1'b0},
    '{1'b0, CFG_FF_GAIN_0, 32'sh0, 16'sh8000, 16'sh7FFF, 1'b1, 32'sh0, 1'b0},
    // unity gain on the current error: drive is the error in Q16.16
    '{1'b1, CFG_FF_GAIN_0, UNITY, 16'sh0, 16'sh0, 1'b0, 32'sh0, 1'b0},
    // past the upper limit, past the lower limit
    '{1'b0, CFG_FF_GAIN_0, 32'sh0, 16'sh7FFF, 16'sh8000, 1'b1, DRIVE_HI, 1'b1},
    '{1'b0, CFG_FF_GAIN_0, 32'sh0, 16'sh8000, 16'sh7FFF, 1'b1, DRIVE_LO, 1'b1},
    // landing exactly on a limit is not a clamp; then zero and one-lsb errors
    '{1'b0, CFG_FF_GAIN_0, 32'sh0, 16'sh7FFF, 16'sh0000, 1'b1, DRIVE_HI, 1'b0},
    '{1'b0, CFG_FF_GAIN_0, 32'sh0, 16'sh8000, 16'sh0000, 1'b1, DRIVE_LO, 1'b0},
    '{1'b0, CFG_FF_GAIN_0, 32'sh0, 16'sh7FFF, 16'sh7FFF, 1'b1, 32'sh0, 1'b0},
    '{1'b0, CFG_FF_GAIN_0, 32'sh0, 16'sh0000, 16'shFFFF, 1'b1, 32'sh0001_0000, 1'b0},
    // write to the undecoded index must leave every gain alone
    '{1'b1, CFG_SPARE, GAIN_MAX, 16'sh0, 16'sh0, 1'b0, 32'sh0, 1'b0},
    '{1'b0, CFG_FF_GAIN_0, 32'sh0, 16'sh0005, 16'sh0003, 1'b1, 32'sh0002_0000, 1'b0},
    // tiny gain puts the sum right around half an output lsb
    '{1'b1, CFG_FF_GAIN_0, 32'sh0000_0080, 16'sh0, 16'sh0, 1'b0, 32'sh0, 1'b0},
    '{1'b0, CFG_FF_GAIN_0, 32'sh0, 16'sh0001, 16'sh0000, 1'b0, 32'sh0, 1'b0},
    '{1'b0, CFG_FF_GAIN_0, 32'sh0, 16'sh0000, 16'sh0001, 1'b0, 32'sh0, 1'b0},
    '{1'b0, CFG_FF_GAIN_0, 32'sh0, 16'sh0000, 16'sh0002, 1'b0, 32'sh0, 1'b0},
    // new gains on every remaining tap: extremes, but -1 lsb on ff3 and 0.5 on fb3
    '{1'b1, CFG_FF_GAIN_1, GAIN_MIN, 16'sh0, 16'sh0, 1'b0, 32'sh0, 1'b0},
    '{1'b1, CFG_FF_GAIN_2, GAIN_MAX, 16'sh0, 16'sh0, 1'b0, 32'sh0, 1'b0},
    '{1'b1, CFG_FF_GAIN_3, 32'shFFFF_FFFF, 16'sh0, 16'sh0, 1'b0, 32'sh0, 1'b0},
    '{1'b1, CFG_FB_GAIN_1, GAIN_MIN, 16'sh0, 16'sh0, 1'b0, 32'sh0, 1'b0},
    '{1'b1, CFG_FB_GAIN_2, GAIN_MAX, 16'sh0, 16'sh0, 1'b0, 32'sh0, 1'b0},
    '{1'b1, CFG_FB_GAIN_3, 32'sh0080_0000, 16'sh0, 16'sh0, 1'b0, 32'sh0, 1'b0},
    '{1'b0, CFG_FF_GAIN_0, 32'sh0, 16'sh7FFF, 16'sh8000, 1'b0, 32'sh0, 1'b0},
    '{1'b0, CFG_FF_GAIN_0, 32'sh0, 16'sh8000, 16'sh7FFF, 1'b0, 32'sh0, 1'b0},
    '{1'b0, CFG_FF_GAIN_0, 32'sh0, 16'sh0000, 16'sh0000, 1'b0, 32'sh0, 1'b0},
    '{1'b0, CFG_FF_GAIN_0, 32'sh0, 16'shFFFF, 16'sh0001, 1'b0, 32'sh0, 1'b0},
    '{1'b0, CFG_FF_GAIN_0, 32'sh0, 16'sh1234, 16'shEDCB, 1'b0, 32'sh0, 1'b0},
    '{1'b0, CFG_FF_GAIN_0, 32'sh0, 16'sh7FFF, 16'sh8000, 1'b0, 32'sh0, 1'b0}};

  logic clk = 1'b0;
  logic rst;

  toic_in_if  sample_ch ();
  toic_out_if result_ch ();
  toic_cfg_if cfg_ch ();

  third_order_iir_compensator_core dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // gain mirror and filter history, widened so every product is exact
  longint ff_coef [4];
  longint fb_coef [4];   // entry 0 unused, taps one to three back
  longint err_hist [3];  // errors one, two, three samples back
  longint drv_hist [3];  // outputs one, two, three samples back

  drive_rec_t drive_q [$];   // expected drives, oldest first
  row_t       pinned_q [$];  // directed rows in flight, one per directed sample

  // two-state counters start at zero
  int sent_count;
  int got_count;
  int write_count;
  int err_count;
  int clamp_count;
  int idle_cycles;
  int hold_left;
  bit idle_on;

  task automatic flag_error(input string what, input longint got, input longint want);
    err_count++;
    if (err_count <= REPORT_CAP) begin
      $display("ERROR @%0t %s: got %0d, expected %0d", $time, what, got, want);
    end
  endtask

  function automatic void load_gain(input cfg_idx_t idx, input coef_t val);
    case (idx)
      CFG_FF_GAIN_0: ff_coef[0] = val;
      CFG_FF_GAIN_1: ff_coef[1] = val;
      CFG_FF_GAIN_2: ff_coef[2] = val;
      CFG_FF_GAIN_3: ff_coef[3] = val;
      CFG_FB_GAIN_1: fb_coef[1] = val;
      CFG_FB_GAIN_2: fb_coef[2] = val;
      CFG_FB_GAIN_3: fb_coef[3] = val;
      default: ;  // undecoded index: nothing changes
    endcase
  endfunction

  // one sample through the difference equation, clamp, then history shift
  function automatic drive_rec_t step_compensator(input sample_t setpt, input sample_t fbk);
    longint     e0;
    longint     acc;
    longint     y;
    longint     hi;
    longint     lo;
    int         k;
    drive_rec_t rec;
    e0  = longint'(setpt) - longint'(fbk);
    acc = ff_coef[0] * e0 + ff_coef[1] * err_hist[0]
        + ff_coef[2] * err_hist[1] + ff_coef[3] * err_hist[2];
    // feedback products drop 16 fraction bits, flooring
    for (k = 1; k <= 3; k++) begin
      acc -= (fb_coef[k] * drv_hist[k-1]) >>> FB_SHIFT;
    end
    // round half up to Q16.16
    y  = (acc + 128) >>> RND_SHIFT;
    hi = longint'(UPPER_LIMIT) * 65536;
    lo = longint'(LOWER_LIMIT) * 65536;
    rec.clamped = 1'b0;
    // upper check first, so crossed limits would leave the lower one in force
    if (y > hi) begin
      y = hi;
      rec.clamped = 1'b1;
    end
    if (y < lo) begin
      y = lo;
      rec.clamped = 1'b1;
    end
    rec.drive   = drive_t'(y);
    err_hist[2] = err_hist[1];
    err_hist[1] = err_hist[0];
    err_hist[0] = e0;
    drv_hist[2] = drv_hist[1];
    drv_hist[1] = drv_hist[0];
    drv_hist[0] = longint'(rec.drive);
    return rec;
  endfunction

  function automatic coef_t pick_gain(input gain_style_t style, input bit feedback);
    coef_t g;
    case (style)
      GAINS_ZERO: g = '0;
      // feedback taps of at most a quarter each keep the loop from running away
      GAINS_STABLE: g = feedback ? coef_t'(int'($urandom_range(0, 1 << 23)) - (1 << 22))
                                 : coef_t'(int'($urandom_range(0, 1 << 25)) - (1 << 24));
      GAINS_FF_ONLY: g = feedback ? coef_t'(0) : coef_t'($urandom);
      GAINS_WILD: g = coef_t'($urandom);
      default: begin
        case ($urandom_range(0, 3))
          0: g = GAIN_MIN;
          1: g = GAIN_MAX;
          2: g = UNITY;
          default: g = -UNITY;
        endcase
      end
    endcase
    return g;
  endfunction

  // mostly full-range samples, some small ones for the stable filters, some rails and near-zero values
  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return sample_t'($urandom);
      5, 6, 7: return sample_t'(int'($urandom_range(0, 600)) - 300);
      default: begin
        case ($urandom_range(0, 4))
          0: return 16'sh7FFF;
          1: return 16'sh8000;
          2: return 16'sh0000;
          3: return 16'shFFFF;
          default: return 16'sh0001;
        endcase
      end
    endcase
  endfunction

  // hold valid until the core takes the sample, with an occasional gap in front while idling is on
  task automatic send_sample(input sample_t setpt, input sample_t fbk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      sample_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    sample_ch.valid     <= 1'b1;
    sample_ch.reference <= setpt;
    sample_ch.measured  <= fbk;
    do @(posedge clk); while (!sample_ch.ready);
    sent_count++;
  endtask

  // valid stays up across back-to-back writes; callers drop it afterwards
  task automatic write_gain(input cfg_idx_t idx, input coef_t val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // stop sending, let every result come back, then give the pipeline a moment
  task automatic drain_results();
    sample_ch.valid <= 1'b0;
    wait (got_count >= sent_count);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side: held off in reset, then random stall bursts while idling is on
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      result_ch.ready <= 1'b0;
      hold_left       <= $urandom_range(0, 3);
    end else begin
      result_ch.ready <= 1'b1;
    end
  end

  // transfer monitor: mirrors gain writes, predicts on each sample, checks each result
  always @(posedge clk) begin
    drive_rec_t want;
    row_t       pin;
    if (!rst) begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        load_gain(cfg_ch.index, cfg_ch.data);
        write_count++;
      end
      if (result_ch.valid && result_ch.ready) begin
        got_count++;
        if (drive_q.size() == 0) begin
          flag_error("result with nothing outstanding, drive", result_ch.drive, 0);
        end else begin
          want = drive_q.pop_front();
          if (result_ch.drive !== want.drive) begin
            flag_error("drive", result_ch.drive, want.drive);
          end
          if (result_ch.clamped !== want.clamped) begin
            flag_error("clamped", result_ch.clamped, want.clamped);
          end
        end
      end
      if (sample_ch.valid && sample_ch.ready) begin
        // predictor runs on every sample so the history stays in step
        want = step_compensator(sample_ch.reference, sample_ch.measured);
        if (pinned_q.size() != 0) begin
          pin = pinned_q.pop_front();
          if (pin.pinned) begin
            want.drive   = pin.drive;
            want.clamped = pin.clamped;
          end
        end
        if (want.clamped) begin
          clamp_count++;
        end
        drive_q.push_back(want);
      end
    end
  end

  // watchdog on cycles with no transfer on any channel
  always @(posedge clk) begin
    if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", idle_cycles);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    bit          prev_write;
    gain_style_t style;
    int          ph;
    int          n;
    int          r;
    sent_count  = 0;
    idle_on     = 1'b1;
    rst                 <= 1'b1;
    sample_ch.valid     <= 1'b0;
    sample_ch.reference <= '0;
    sample_ch.measured  <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.index        <= CFG_FF_GAIN_0;
    cfg_ch.data         <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed table: writes only once the core has gone quiet
    prev_write = 1'b0;
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].is_write) begin
        if (!prev_write) begin
          drain_results();
        end
        write_gain(DIRECTED[i].idx, DIRECTED[i].gain);
      end else begin
        if (prev_write) begin
          cfg_ch.valid <= 1'b0;
        end
        pinned_q.push_back(DIRECTED[i]);
        send_sample(DIRECTED[i].setpt, DIRECTED[i].fbk);
      end
      prev_write = DIRECTED[i].is_write;
    end

    // random phases, each under a fresh set of gains
    for (ph = 0; ph < N_PHASES; ph++) begin
      drain_results();
      idle_on = (ph < N_PHASES - N_QUIET);
      style   = PHASE_PLAN[ph];
      for (r = 0; r < 7; r++) begin
        write_gain(GAIN_REGS[r], pick_gain(style, GAIN_REGS[r] >= CFG_FB_GAIN_1));
      end
      if ($urandom_range(0, 2) == 0) begin
        write_gain(CFG_SPARE, coef_t'($urandom));
      end
      cfg_ch.valid <= 1'b0;
      for (n = 0; n < PHASE_SAMPLES; n++) begin
        send_sample(pick_sample(), pick_sample());
      end
    end

    sample_ch.valid <= 1'b0;
    wait (got_count >= sent_count);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (drive_q.size() != 0) begin
      flag_error("results never delivered", drive_q.size(), 0);
    end

    $display("run covered %0d samples (%0d hit a limit) and %0d register writes",
             sent_count, clamp_count, write_count);
    $display("directed rows: %0d, random gain phases: %0d, mismatches: %0d",
             N_DIRECTED, N_PHASES, err_count);
    if (err_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
